// ===== design/bnp_pkg.sv =====
// Package for the nearest-plane solver: sizes, command codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
package bnp_pkg;
  localparam int MaxSize  = 32;
  localparam int TriDepth = MaxSize * (MaxSize + 1) / 2;
  localparam int IdxW     = $clog2(MaxSize);
  localparam int TriW     = $clog2(TriDepth);
  localparam int SizeW    = $clog2(MaxSize + 1);

  typedef enum logic [1:0] {
    CmdWrCoeff  = 2'd0,
    CmdWrTarget = 2'd1,
    CmdSolve    = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  localparam logic [1:0] RegActiveSize = 2'd0;
  localparam logic [1:0] RegBoxEnable  = 2'd1;
  localparam logic [1:0] RegUpperBound = 2'd2;

  // Packed upper-triangle address of (r, c), c >= r.
  function automatic logic [TriW-1:0] tri_addr(input logic [IdxW-1:0] r,
                                               input logic [IdxW-1:0] c);
    logic [TriW+IdxW:0] a;
    a = (TriW+IdxW+1)'(r) * (TriW+IdxW+1)'(MaxSize)
      - (((TriW+IdxW+1)'(r) * ((TriW+IdxW+1)'(r)
          - {{(TriW+IdxW){1'b0}}, (r != '0)})) >> 1)
      + (TriW+IdxW+1)'(c) - (TriW+IdxW+1)'(r);
    return a[TriW-1:0];
  endfunction
endpackage

// ===== design/bnp_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bnp_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/bnp_divider.sv =====
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
// Depends on nothing outside itself.
`timescale 1ns / 1ps
module bnp_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] sh;
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    sh = {rem_q, quo_q[63]};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[62:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        rem_d = 64'(sh - {1'b0, den_q}); quo_d[0] = 1'b1;
      end else rem_d = sh[63:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end
  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ===== design/babai_nearest_plane_solver.sv =====
// Babai nearest-plane back substitution over RAM-held R and y (Q16.16).
// Load words are accepted while the solver is idle. A solve of size n works
// per row i through a multiply-accumulate over columns i+1..n-1, the 64-step
// serial divide and the sequencing states, and stalls when the output is full.
// Results leave through one output register, index n-1 first, tlast on 0.
// Reset clears control and config registers; RAMs are undefined until written.
`timescale 1ns / 1ps
module babai_nearest_plane_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: value[31:0], col[36:32], row[41:37], zeros to 47
  input  logic [47:0] s_axis_tdata_i,
  // tuser: command[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: sol_index[4:0], sol_value[20:5], zero_pivot[21], zeros to 23
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  localparam int IdxW = bnp_pkg::IdxW;
  localparam int TriW = bnp_pkg::TriW;
  localparam logic [3:0] StIdle = 4'd0, StRow = 4'd1, StRd = 4'd2, StWt = 4'd3,
    StMac = 4'd4, StPiv = 4'd5, StDiv = 4'd6, StDivW = 4'd7, StFin = 4'd8, StOut = 4'd9;

  logic [3:0] st_q, st_d;
  logic [5:0] size_q; logic box_q; logic [14:0] ub_q;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] piv_q, piv_d;
  logic [IdxW-1:0] n1_q, n1_d;

  // configuration
  logic cfg_wr;
  assign pready_o = 1'b1;
  assign cfg_wr = psel_i & penable_i & pwrite_i;
  always_comb begin
    prdata_o = '0;
    unique case (paddr_i[3:2])
      bnp_pkg::RegActiveSize: prdata_o = {26'd0, size_q};
      bnp_pkg::RegBoxEnable:  prdata_o = {31'd0, box_q};
      bnp_pkg::RegUpperBound: prdata_o = {17'd0, ub_q};
      default:                prdata_o = '0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 6'd32; box_q <= 1'b0; ub_q <= 15'd1;
    end else if (cfg_wr && paddr_i[1:0] == 2'b00) begin
      if (paddr_i[3:2] == bnp_pkg::RegActiveSize) size_q <= pwdata_i[5:0];
      if (paddr_i[3:2] == bnp_pkg::RegBoxEnable)  box_q  <= pwdata_i[0];
      if (paddr_i[3:2] == bnp_pkg::RegUpperBound) ub_q   <= pwdata_i[14:0];
    end
  end

  // input word
  logic in_acc;
  logic [1:0] cmd; logic [4:0] w_row, w_col; logic [31:0] w_val;
  assign s_axis_tready_o = (st_q == StIdle);
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign cmd = s_axis_tuser_i;
  assign w_val = s_axis_tdata_i[31:0];
  assign w_col = s_axis_tdata_i[36:32];
  assign w_row = s_axis_tdata_i[41:37];

  // memories
  logic c_we; logic [TriW-1:0] c_ra; logic [31:0] c_rd;
  logic t_we; logic [IdxW-1:0] t_ra; logic [31:0] t_rd;
  logic s_we; logic [IdxW-1:0] s_ra; logic [15:0] s_rd, z16;
  assign c_we = in_acc && cmd == bnp_pkg::CmdWrCoeff && w_col >= w_row;
  assign t_we = in_acc && cmd == bnp_pkg::CmdWrTarget;
  assign s_we = (st_q == StFin);
  bnp_ram #(.Width(32), .Depth(bnp_pkg::TriDepth)) u_coeff (
    .clk_i, .we_i(c_we), .waddr_i(bnp_pkg::tri_addr(w_row, w_col)), .wdata_i(w_val),
    .raddr_i(c_ra), .rdata_o(c_rd));
  bnp_ram #(.Width(32), .Depth(bnp_pkg::MaxSize)) u_target (
    .clk_i, .we_i(t_we), .waddr_i(w_row), .wdata_i(w_val),
    .raddr_i(t_ra), .rdata_o(t_rd));
  bnp_ram #(.Width(16), .Depth(bnp_pkg::MaxSize)) u_sol (
    .clk_i, .we_i(s_we), .waddr_i(i_q), .wdata_i(z16),
    .raddr_i(s_ra), .rdata_o(s_rd));

  // read addresses: issue column j from j_d so its data meets the
  // product register; pivot read at (i,i)
  always_comb begin
    t_ra = i_q; s_ra = j_d;
    c_ra = (st_q == StPiv) ? bnp_pkg::tri_addr(i_q, i_q) : bnp_pkg::tri_addr(i_q, j_d);
  end

  // product register after multiplier
  logic signed [47:0] prod_q;
  always_ff @(posedge clk_i) prod_q <= $signed(c_rd) * $signed(s_rd);

  // divider on magnitudes with rounding: (2|num|+|den|)/(2|den|)
  // the pivot is on the RAM output while the divider starts
  logic div_start, div_done; logic [63:0] div_q, an, ad;
  logic neg;
  assign an = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign ad = {32'd0, c_rd[31] ? 32'(~c_rd + 32'd1) : c_rd};
  assign div_start = (st_q == StDiv);
  bnp_divider u_div (.clk_i, .rst_ni, .start_i(div_start),
    .num_i({an[62:0], 1'b0} + ad), .den_i({ad[62:0], 1'b0}),
    .done_o(div_done), .quot_o(div_q));
  assign neg = acc_q[63] ^ piv_q[31];

  // clamp / saturate
  logic [15:0] z_q, z_d; logic zp_q, zp_d;
  always_comb begin
    z16 = z_q;
  end
  logic signed [64:0] zs;
  always_comb begin
    zs = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (box_q) begin
      if (zs < 0) z_d = '0;
      else if (zs > $signed({50'd0, ub_q})) z_d = {1'b0, ub_q};
      else z_d = zs[15:0];
    end else begin
      if (zs < -65'sd32768) z_d = 16'h8000;
      else if (zs > 65'sd32767) z_d = 16'h7fff;
      else z_d = zs[15:0];
    end
  end

  // output register
  logic ov_q; logic [23:0] od_q; logic ol_q;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = od_q;
  assign m_axis_tlast_o = ol_q;

  logic [5:0] nsz;
  always_comb begin
    nsz = size_q;
    if (nsz == 6'd0) nsz = 6'd1;
    if (nsz > 6'(bnp_pkg::MaxSize)) nsz = 6'(bnp_pkg::MaxSize);
  end

  always_comb begin
    st_d = st_q; i_d = i_q; j_d = j_q; acc_d = acc_q; piv_d = piv_q; n1_d = n1_q;
    unique case (st_q)
      StIdle: if (in_acc && cmd == bnp_pkg::CmdSolve) begin
        n1_d = IdxW'(nsz - 6'd1); i_d = IdxW'(nsz - 6'd1); st_d = StRow;
      end
      StRow: begin j_d = i_q + 1'b1; st_d = StRd; end // target read issued
      StRd: begin
        acc_d = 64'(signed'(t_rd));
        st_d = (i_q == n1_q) ? StPiv : StWt;
      end
      StWt: st_d = StMac; // RAM data -> product register
      StMac: begin
        acc_d = acc_q - 64'(prod_q);
        if (j_q == n1_q) st_d = StPiv;
        else begin j_d = j_q + 1'b1; st_d = StWt; end
      end
      StPiv: st_d = StDiv; // pivot read issued
      StDiv: begin piv_d = c_rd; st_d = StDivW; end
      StDivW: if (div_done) st_d = StFin;
      StFin: st_d = StOut;
      StOut: if (!ov_q || m_axis_tready_i) begin
        if (i_q == '0) st_d = StIdle;
        else begin i_d = i_q - 1'b1; st_d = StRow; end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StOut && (!ov_q || m_axis_tready_i)) ov_q <= 1'b1;
      else if (m_axis_tready_i) ov_q <= 1'b0;
    end
  end
  logic zero_piv;
  assign zero_piv = (piv_q == '0);
  // hold the pivot for the sign and zero checks of the row
  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; acc_q <= acc_d; n1_q <= n1_d;
    piv_q <= piv_d;
    if (st_q == StDivW && div_done) begin
      z_q <= zero_piv ? 16'd0 : z_d; zp_q <= zero_piv;
    end
    if (st_q == StOut && (!ov_q || m_axis_tready_i)) begin
      od_q <= {2'b00, zp_q, z_q, 5'(i_q)};
      ol_q <= (i_q == '0);
    end
  end
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for babai_nearest_plane_solver: directed table, then
// random load/solve phases checked word by word against a behavioral predictor.
// Depends on bnp_pkg (command and register codes) and the solver RTL.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    bit              cfg;      // row only reprograms the registers
    logic [5:0]      size;
    logic            box;
    logic [14:0]     ub;
    bnp_pkg::cmd_e   cmd;
    logic [4:0]      row;
    logic [4:0]      col;
    logic [31:0]     val;
    bit              has_exp;  // single result typed in below
    logic [15:0]     exp_val;
    bit              exp_zp;
  } stim_row_t;

  typedef struct {
    logic [4:0]  idx;
    logic [15:0] val;
    logic        zp;
    logic        last;
  } sol_word_t;

  logic        clk_i, rst_ni;
  logic        s_valid, s_ready, m_valid, m_ready, m_last;
  logic [47:0] s_data;
  logic [1:0]  s_user;
  logic [23:0] m_data;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  babai_nearest_plane_solver u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tlast_o(m_last),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  // Shadow state of the solver.
  logic signed [31:0] coeff_sh [32][32];
  logic signed [31:0] target_sh [32];
  logic signed [15:0] sol_sh [32];
  bit                 coeff_ok [32][32];
  bit                 target_ok [32];
  logic [5:0]         size_sh;
  logic               box_sh;
  logic [14:0]        ub_sh;

  sol_word_t sol_q[$];
  int        errors;
  int        items_sent;
  bit        no_idle;

  // Directed rows: extremes, rounding, clamping, zero pivot, ignored writes.
  stim_row_t dir_tab [] = '{
    '{1, 6'd1, 1'b0, 15'd1, bnp_pkg::CmdNone, 5'd0, 5'd0, 32'h0, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd0, 5'd0, 32'h0000_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd0, 5'd0, 32'h1234_5678, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'h0000, 1},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd0, 5'd0, 32'h0001_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd0, 5'd0, 32'h7FFF_FFFF, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'h7FFF, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd0, 5'd0, 32'h8000_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'h8000, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd0, 5'd0, 32'hFFFF_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd0, 5'd0, 32'h0001_8000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'hFFFE, 0},
    '{1, 6'd1, 1'b1, 15'd32767, bnp_pkg::CmdNone, 5'd0, 5'd0, 32'h0, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd0, 5'd0, 32'h7FFF_FFFF, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'h0000, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd0, 5'd0, 32'h0001_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'h7FFF, 0},
    '{1, 6'd1, 1'b1, 15'd0, bnp_pkg::CmdNone, 5'd0, 5'd0, 32'h0, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'h0000, 0},
    '{1, 6'd0, 1'b0, 15'd1, bnp_pkg::CmdNone, 5'd0, 5'd0, 32'h0, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 1, 16'h7FFF, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd1, 5'd0, 32'hFFFF_FFFF, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdNone, 5'd31, 5'd31, 32'hFFFF_FFFF, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd31, 5'd31, 32'h8000_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd31, 5'd0, 32'hFFFF_FFFF, 0, 16'h0, 0},
    '{1, 6'd2, 1'b0, 15'd1, bnp_pkg::CmdNone, 5'd0, 5'd0, 32'h0, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd1, 5'd1, 32'h0002_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrCoeff, 5'd0, 5'd1, 32'h0001_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd1, 5'd0, 32'h0005_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdWrTarget, 5'd0, 5'd0, 32'h0003_0000, 0, 16'h0, 0},
    '{0, 6'd0, 1'b0, 15'd0, bnp_pkg::CmdSolve, 5'd0, 5'd0, 32'h0, 0, 16'h0, 0}
  };

  // 10 ns clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Quotient rounded half away from zero.
  function automatic longint round_div(input longint num, input longint den);
    longint unsigned an, ad, q;
    an = (num < 0) ? longint'(-num) : longint'(num);
    ad = (den < 0) ? longint'(-den) : longint'(den);
    q  = (2 * an + ad) / (2 * ad);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Back substitution on the shadow stores; queue the words unless told not to.
  task automatic predict_solve(input bit keep);
    int     n, i, j;
    longint num, piv, z;
    bit     zp;
    n = (size_sh == 0) ? 1 : ((size_sh > 32) ? 32 : int'(size_sh));
    for (i = n - 1; i >= 0; i--) begin
      num = longint'(target_sh[i]);
      piv = longint'(coeff_sh[i][i]);
      zp  = 1'b0;
      for (j = i + 1; j < n; j++) num -= longint'(coeff_sh[i][j]) * longint'(sol_sh[j]);
      if (piv == 0) begin
        z  = 0;
        zp = 1'b1;
      end else begin
        z = round_div(num, piv);
        if (box_sh) begin
          if (z < 0) z = 0;
          if (z > longint'(ub_sh)) z = longint'(ub_sh);
        end else begin
          if (z < -32768) z = -32768;
          if (z > 32767) z = 32767;
        end
      end
      sol_sh[i] = z[15:0];
      if (keep) sol_q.push_back('{i[4:0], z[15:0], zp, (i == 0)});
    end
  endtask

  task automatic predict_word(input bnp_pkg::cmd_e cmd, input logic [4:0] r,
                              input logic [4:0] c, input logic [31:0] v, input bit keep);
    case (cmd)
      bnp_pkg::CmdWrCoeff: begin
        if (c >= r) begin
          coeff_sh[r][c] = v;
          coeff_ok[r][c] = 1'b1;
        end
      end
      bnp_pkg::CmdWrTarget: begin
        target_sh[r] = v;
        target_ok[r] = 1'b1;
      end
      bnp_pkg::CmdSolve: predict_solve(keep);
      default: ;
    endcase
  endtask

  // Drive one word, hold tvalid until the accepting edge, leave it high.
  task automatic send_word(input bnp_pkg::cmd_e cmd, input logic [4:0] r,
                           input logic [4:0] c, input logic [31:0] v, input bit keep);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {6'b0, r, c, v};
    do @(negedge clk_i); while (!s_ready);
    @(posedge clk_i);
    items_sent++;
    predict_word(cmd, r, c, v, keep);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain every pending result, let the engine settle, then reprogram.
  task automatic set_regs(input logic [5:0] n, input logic box, input logic [14:0] ub);
    s_valid <= 1'b0;
    wait (sol_q.size() == 0);
    repeat (30) @(posedge clk_i);
    apb_write(bnp_pkg::RegActiveSize, {26'b0, n});
    apb_write(bnp_pkg::RegBoxEnable, {31'b0, box});
    apb_write(bnp_pkg::RegUpperBound, {17'b0, ub});
    size_sh = n;
    box_sh  = box;
    ub_sh   = ub;
  endtask

  function automatic logic [31:0] rand_value(input bit diag);
    int k;
    if ($urandom_range(0, 7) == 0) return $urandom;
    if (diag) begin
      if ($urandom_range(0, 15) == 0) return 32'h0;
      k = $urandom_range(0, 7) - 4;
      if (k == 0) k = 1;
      return (k <<< 16) + $urandom_range(0, 65535);
    end
    return $signed($urandom) >>> 12;
  endfunction

  // Fill whatever the next solve would read but was never written.
  task automatic fill_missing(input int n);
    int i, j;
    for (i = 0; i < n; i++) begin
      for (j = i; j < n; j++)
        if (!coeff_ok[i][j])
          send_word(bnp_pkg::CmdWrCoeff, i[4:0], j[4:0], rand_value(i == j), 1'b1);
      if (!target_ok[i])
        send_word(bnp_pkg::CmdWrTarget, i[4:0], 5'd0, rand_value(1'b0), 1'b1);
    end
  endtask

  task automatic random_word(input int n);
    int       pick;
    logic [4:0] r, c;
    pick = $urandom_range(0, 99);
    r = 5'($urandom_range(0, n - 1));
    c = 5'($urandom_range(r, n - 1));
    if (pick < 10)
      send_word(bnp_pkg::CmdNone, 5'($urandom), 5'($urandom), $urandom, 1'b1);
    else if (pick < 18)
      send_word(bnp_pkg::CmdWrCoeff, 5'($urandom_range(1, 31)), 5'd0, $urandom, 1'b1);
    else if (pick < 25)
      send_word(bnp_pkg::CmdWrCoeff, 5'($urandom), 5'($urandom), $urandom, 1'b1);
    else if (pick < 65)
      send_word(bnp_pkg::CmdWrCoeff, r, c, rand_value(r == c), 1'b1);
    else
      send_word(bnp_pkg::CmdWrTarget, r, 5'($urandom), rand_value(1'b0), 1'b1);
  endtask

  // Result checker: a word seen at the falling edge is taken at the next rising edge.
  always @(negedge clk_i) begin
    sol_word_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (sol_q.size() == 0) begin
        report("unexpected word", 32'(m_data), 32'd0);
      end else begin
        want = sol_q.pop_front();
        if (m_data[4:0] != want.idx)
          report("sol_index", 32'(m_data[4:0]), 32'(want.idx));
        if (m_data[20:5] != want.val)
          report("sol_value", 32'(m_data[20:5]), 32'(want.val));
        if (m_data[21] != want.zp)
          report("zero_pivot", 32'(m_data[21]), 32'(want.zp));
        if (m_last != want.last)
          report("tlast", 32'(m_last), 32'(want.last));
      end
    end
  end

  // Receiver: random stall before each word.
  initial begin
    int w;
    m_ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        m_ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(negedge clk_i); while (!m_valid);
      @(posedge clk_i);
    end
  end

  // Watchdog: too long without any word moving on either side.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
      if (quiet >= 20000) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int     ph, k, s, n;
    logic [5:0]  nsel;
    logic [14:0] ubsel;
    s_valid = 1'b0;
    s_data  = '0;
    s_user  = bnp_pkg::CmdNone;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    errors  = 0;
    items_sent = 0;
    no_idle = 1'b0;
    size_sh = 6'd32;
    box_sh  = 1'b0;
    ub_sh   = 15'd1;
    for (int i = 0; i < 32; i++) begin
      target_ok[i] = 1'b0;
      sol_sh[i]    = '0;
      for (int j = 0; j < 32; j++) coeff_ok[i][j] = 1'b0;
    end
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: typed expectations where the answer is obvious.
    foreach (dir_tab[t]) begin
      if (dir_tab[t].cfg) begin
        set_regs(dir_tab[t].size, dir_tab[t].box, dir_tab[t].ub);
      end else begin
        send_word(dir_tab[t].cmd, dir_tab[t].row, dir_tab[t].col, dir_tab[t].val,
                  !dir_tab[t].has_exp);
        if (dir_tab[t].has_exp)
          sol_q.push_back('{5'd0, dir_tab[t].exp_val, dir_tab[t].exp_zp, 1'b1});
      end
    end

    // Random phases: reprogram while idle, then loads and solves.
    ph = 0;
    while (items_sent < 300 || ph < 8) begin
      if (ph == 2) nsel = 6'd63;           // saturates to the full size
      else if (ph == 5) nsel = 6'd32;
      else if ($urandom_range(0, 7) == 0) nsel = 6'd0;
      else nsel = 6'($urandom_range(1, 6));
      case ($urandom_range(0, 3))
        0: ubsel = 15'd0;
        1: ubsel = 15'd32767;
        default: ubsel = 15'($urandom_range(0, 20));
      endcase
      set_regs(nsel, 1'($urandom_range(0, 1)), ubsel);
      no_idle = (ph % 3 == 1);
      n = (nsel == 0) ? 1 : ((nsel > 32) ? 32 : int'(nsel));
      s = $urandom_range(1, 3);
      for (k = 0; k < s; k++) begin
        repeat ($urandom_range(0, 2 * n + 2)) random_word(n);
        fill_missing(n);
        send_word(bnp_pkg::CmdSolve, 5'($urandom), 5'($urandom), $urandom, 1'b1);
      end
      ph++;
    end

    s_valid <= 1'b0;
    wait (sol_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && sol_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
